### rtl/core/ple_pkg.sv
`timescale 1ns / 1ps
// Shared types for the positional list engine: command and status codes,
// and the command/status bundles between controller and datapath. No dependencies.
package ple_pkg;

	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0,
		CMD_DELETE = 3'd1,
		CMD_READ   = 3'd2,
		CMD_LOCATE = 3'd3,
		CMD_COUNT  = 3'd4,
		CMD_CLEAR  = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_POS   = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOT_FOUND = 3'd4
	} st_t;

	// read address select, shared by both stores
	typedef enum logic [1:0] {
		RA_NODE = 2'd0,
		RA_PTR  = 2'd1,
		RA_LINK = 2'd2
	} ra_t;

	// link store write select
	typedef enum logic [2:0] {
		LW_NONE       = 3'd0,
		LW_SWEEP      = 3'd1,
		LW_NODE_FIRST = 3'd2,
		LW_NODE_LINK  = 3'd3,
		LW_NODE_FREE  = 3'd4,
		LW_PTR_NODE   = 3'd5,
		LW_PTR_LINK   = 3'd6
	} lw_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic clr;
		logic sweep;
		logic rd;
		ra_t  ra;
		lw_t  lw;
		logic iwr;
		logic free_take;
		logic free_put;
		logic first_node;
		logic first_link;
		logic node_take;
		logic adv;
		logic dec;
		logic kinc;
		logic inc;
		logic del;
		logic rval_load;
		logic fpos_load;
		logic emit;
		st_t  emit_st;
	} ctl_cmd_t;

	typedef struct packed {
		cmd_t op;
		st_t  err;
		logic pos_one;
		logic steps_zero;
		logic match;
		logic last;
		logic sweep_last;
	} ctl_sts_t;

endpackage

### rtl/core/positional_list_engine.sv
`timescale 1ns / 1ps
// Positional list engine: ordered byte list held as linked nodes with a free list.
// The walk follows one link per cycle through the link store read port.
// Reset and clear run a sweep over all nodes to rebuild the free chain; busy is high.
// One command at a time; the next is taken while done is high, except after a clear,
// which sweeps first. Done cannot be stalled.
module positional_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] command,
	input  logic [7:0] position,
	input  logic [7:0] item_value,
	output logic       done,
	output logic [2:0] status,
	output logic [7:0] result_value,
	output logic [7:0] found_position,
	output logic [7:0] item_count
);

	import ple_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	ple_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	ple_dpath #(.CAPACITY(CAPACITY)) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.command        (command),
		.position       (position),
		.item_value     (item_value),
		.done           (done),
		.status         (status),
		.result_value   (result_value),
		.found_position (found_position),
		.item_count     (item_count)
	);

endmodule

### rtl/core/ple_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ple_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/ple_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for the positional list engine.
// Depends on ple_pkg.
module ple_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ple_pkg::ctl_sts_t sts,
	output logic              busy,
	output ple_pkg::ctl_cmd_t cmd
);

	import ple_pkg::*;

	typedef enum logic [4:0] {
		S_SWEEP,
		S_IDLE,
		S_DECODE,
		S_INS_FREE,
		S_INS_TAKE,
		S_WALK0,
		S_WALK,
		S_INS_RDP,
		S_INS_LINKN,
		S_INS_LINKP,
		S_DEL_RDP,
		S_DEL_GETQ,
		S_DEL_RDQ,
		S_DEL_UNLINK,
		S_DEL_FREE,
		S_RD_ITEM,
		S_RD_DONE,
		S_LOC_RD,
		S_LOC_CHK
	} state_t;

	state_t state_q, state_d, post_walk;

	always_comb begin
		unique case (sts.op)
			CMD_INSERT: post_walk = S_INS_RDP;
			CMD_DELETE: post_walk = S_DEL_RDP;
			default:    post_walk = S_RD_ITEM;
		endcase
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				cmd.lw    = LW_SWEEP;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.setup = 1'b1;
				if (sts.err != ST_OK) begin
					cmd.emit    = 1'b1;
					cmd.emit_st = sts.err;
					state_d     = S_IDLE;
				end else begin
					unique case (sts.op)
						CMD_INSERT: state_d = S_INS_FREE;
						CMD_DELETE: state_d = sts.pos_one ? S_DEL_RDQ : S_WALK0;
						CMD_READ:   state_d = S_WALK0;
						CMD_LOCATE: state_d = S_LOC_RD;
						CMD_CLEAR: begin
							cmd.clr  = 1'b1;
							cmd.emit = 1'b1;
							state_d  = S_SWEEP;
						end
						default: begin
							cmd.emit = 1'b1;
							state_d  = S_IDLE;
						end
					endcase
				end
			end
			S_INS_FREE: begin
				cmd.rd  = 1'b1;
				cmd.ra  = RA_NODE;
				state_d = S_INS_TAKE;
			end
			S_INS_TAKE: begin
				cmd.free_take = 1'b1;
				cmd.iwr       = 1'b1;
				if (sts.pos_one) begin
					cmd.lw         = LW_NODE_FIRST;
					cmd.first_node = 1'b1;
					cmd.inc        = 1'b1;
					cmd.emit       = 1'b1;
					state_d        = S_IDLE;
				end else begin
					state_d = S_WALK0;
				end
			end
			S_WALK0: begin
				if (sts.steps_zero) begin
					state_d = post_walk;
				end else begin
					cmd.rd  = 1'b1;
					cmd.ra  = RA_PTR;
					cmd.dec = 1'b1;
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				cmd.adv = 1'b1;
				if (sts.steps_zero) begin
					state_d = post_walk;
				end else begin
					cmd.rd  = 1'b1;
					cmd.ra  = RA_LINK;
					cmd.dec = 1'b1;
				end
			end
			S_INS_RDP: begin
				cmd.rd  = 1'b1;
				cmd.ra  = RA_PTR;
				state_d = S_INS_LINKN;
			end
			S_INS_LINKN: begin
				cmd.lw  = LW_NODE_LINK;
				state_d = S_INS_LINKP;
			end
			S_INS_LINKP: begin
				cmd.lw   = LW_PTR_NODE;
				cmd.inc  = 1'b1;
				cmd.emit = 1'b1;
				state_d  = S_IDLE;
			end
			S_DEL_RDP: begin
				cmd.rd  = 1'b1;
				cmd.ra  = RA_PTR;
				state_d = S_DEL_GETQ;
			end
			S_DEL_GETQ: begin
				cmd.node_take = 1'b1;
				cmd.rd        = 1'b1;
				cmd.ra        = RA_LINK;
				state_d       = S_DEL_UNLINK;
			end
			S_DEL_RDQ: begin
				cmd.rd  = 1'b1;
				cmd.ra  = RA_NODE;
				state_d = S_DEL_UNLINK;
			end
			S_DEL_UNLINK: begin
				cmd.rval_load = 1'b1;
				if (sts.pos_one) begin
					cmd.first_link = 1'b1;
				end else begin
					cmd.lw = LW_PTR_LINK;
				end
				state_d = S_DEL_FREE;
			end
			S_DEL_FREE: begin
				cmd.lw       = LW_NODE_FREE;
				cmd.free_put = 1'b1;
				cmd.del      = 1'b1;
				cmd.emit     = 1'b1;
				state_d      = S_IDLE;
			end
			S_RD_ITEM: begin
				cmd.rd  = 1'b1;
				cmd.ra  = RA_PTR;
				state_d = S_RD_DONE;
			end
			S_RD_DONE: begin
				cmd.rval_load = 1'b1;
				cmd.emit      = 1'b1;
				state_d       = S_IDLE;
			end
			S_LOC_RD: begin
				cmd.rd  = 1'b1;
				cmd.ra  = RA_PTR;
				state_d = S_LOC_CHK;
			end
			S_LOC_CHK: begin
				if (sts.match) begin
					cmd.fpos_load = 1'b1;
					cmd.emit      = 1'b1;
					state_d       = S_IDLE;
				end else if (sts.last) begin
					cmd.emit    = 1'b1;
					cmd.emit_st = ST_NOT_FOUND;
					state_d     = S_IDLE;
				end else begin
					cmd.adv  = 1'b1;
					cmd.kinc = 1'b1;
					cmd.rd   = 1'b1;
					cmd.ra   = RA_LINK;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

### rtl/core/ple_dpath.sv
`timescale 1ns / 1ps
// Datapath for the positional list engine: node stores, list registers,
// walk pointer and result registers. Depends on ple_pkg and ple_ram.
module ple_dpath #(
	parameter int CAPACITY = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ple_pkg::ctl_cmd_t cmd,
	output ple_pkg::ctl_sts_t sts,
	input  logic [2:0]        command,
	input  logic [7:0]        position,
	input  logic [7:0]        item_value,
	output logic              done,
	output logic [2:0]        status,
	output logic [7:0]        result_value,
	output logic [7:0]        found_position,
	output logic [7:0]        item_count
);

	import ple_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [2:0]    cmd_q;
	logic [7:0]    pos_q;
	logic [7:0]    val_q;
	logic [IW-1:0] first_q;
	logic [IW-1:0] free_q;
	logic [CW-1:0] total_q;
	logic [CW-1:0] total_nxt;
	logic [IW-1:0] ptr_q;
	logic [IW-1:0] node_q;
	logic [IW-1:0] sw_q;
	logic [7:0]    steps_q;
	logic [7:0]    kpos_q;
	logic [7:0]    rval_q;
	logic [7:0]    fpos_q;
	logic [2:0]    stat_q;
	logic [7:0]    cnt_q;
	logic          done_q;

	logic [IW-1:0] link_rd;
	logic [7:0]    item_rd;
	logic [IW-1:0] raddr;
	logic          lwe;
	logic [IW-1:0] lwaddr;
	logic [IW-1:0] lwdata;

	cmd_t          op;
	st_t           err;
	logic [8:0]    pos9;
	logic [8:0]    tot9;
	logic          pos_zero;
	logic          ins_bad;
	logic          rng_bad;
	logic          full;

	ple_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_link (
		.clk   (clk),
		.we    (lwe),
		.waddr (lwaddr),
		.wdata (lwdata),
		.re    (cmd.rd),
		.raddr (raddr),
		.rdata (link_rd)
	);

	ple_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_item (
		.clk   (clk),
		.we    (cmd.iwr),
		.waddr (node_q),
		.wdata (val_q),
		.re    (cmd.rd),
		.raddr (raddr),
		.rdata (item_rd)
	);

	always_comb begin
		case (cmd.ra)
			RA_NODE: raddr = node_q;
			RA_LINK: raddr = link_rd;
			default: raddr = ptr_q;
		endcase
	end

	always_comb begin
		lwe    = 1'b1;
		lwaddr = node_q;
		lwdata = first_q;
		case (cmd.lw)
			LW_SWEEP: begin
				lwaddr = sw_q;
				lwdata = (sw_q == IW'(CAPACITY - 1)) ? '0 : sw_q + 1'b1;
			end
			LW_NODE_FIRST: lwdata = first_q;
			LW_NODE_LINK:  lwdata = link_rd;
			LW_NODE_FREE:  lwdata = free_q;
			LW_PTR_NODE: begin
				lwaddr = ptr_q;
				lwdata = node_q;
			end
			LW_PTR_LINK: begin
				lwaddr = ptr_q;
				lwdata = link_rd;
			end
			default: lwe = 1'b0;
		endcase
	end

	// command checks
	assign op       = cmd_t'(cmd_q);
	assign pos9     = {1'b0, pos_q};
	assign tot9     = 9'(total_q);
	assign pos_zero = (pos_q == 8'd0);
	assign ins_bad  = pos_zero || (pos9 > tot9 + 9'd1);
	assign rng_bad  = pos_zero || (pos9 > tot9);
	assign full     = (total_q == CW'(CAPACITY));

	always_comb begin
		case (op)
			CMD_INSERT: err = ins_bad ? ST_BAD_POS : (full ? ST_FULL : ST_OK);
			CMD_DELETE: err = (total_q == '0) ? ST_EMPTY : (rng_bad ? ST_BAD_POS : ST_OK);
			CMD_READ:   err = rng_bad ? ST_BAD_POS : ST_OK;
			CMD_LOCATE: err = (total_q == '0) ? ST_NOT_FOUND : ST_OK;
			default:    err = ST_OK;
		endcase
	end

	always_comb begin
		if (cmd.clr) begin
			total_nxt = '0;
		end else if (cmd.inc) begin
			total_nxt = total_q + 1'b1;
		end else if (cmd.del) begin
			total_nxt = total_q - 1'b1;
		end else begin
			total_nxt = total_q;
		end
	end

	assign sts.op         = op;
	assign sts.err        = err;
	assign sts.pos_one    = (pos_q == 8'd1);
	assign sts.steps_zero = (steps_q == 8'd0);
	assign sts.match      = (item_rd == val_q);
	assign sts.last       = (kpos_q == 8'(total_q));
	assign sts.sweep_last = (sw_q == IW'(CAPACITY - 1));

	// list control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			free_q  <= '0;
			total_q <= '0;
			sw_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			total_q <= total_nxt;
			done_q  <= cmd.emit;
			if (cmd.clr) begin
				first_q <= '0;
				free_q  <= '0;
				sw_q    <= '0;
			end else begin
				if (cmd.sweep) begin
					sw_q <= sw_q + 1'b1;
				end
				if (cmd.first_node) begin
					first_q <= node_q;
				end else if (cmd.first_link) begin
					first_q <= link_rd;
				end
				if (cmd.free_take) begin
					free_q <= link_rd;
				end else if (cmd.free_put) begin
					free_q <= node_q;
				end
			end
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			pos_q <= position;
			val_q <= item_value;
		end
		if (cmd.setup) begin
			ptr_q   <= first_q;
			node_q  <= (op == CMD_INSERT) ? free_q : first_q;
			steps_q <= (op == CMD_READ) ? pos_q - 8'd1 : pos_q - 8'd2;
			kpos_q  <= 8'd1;
			rval_q  <= 8'd0;
			fpos_q  <= 8'd0;
		end else begin
			if (cmd.adv) begin
				ptr_q <= link_rd;
			end
			if (cmd.node_take) begin
				node_q <= link_rd;
			end
			if (cmd.dec) begin
				steps_q <= steps_q - 8'd1;
			end
			if (cmd.kinc) begin
				kpos_q <= kpos_q + 8'd1;
			end
			if (cmd.rval_load) begin
				rval_q <= item_rd;
			end
			if (cmd.fpos_load) begin
				fpos_q <= kpos_q;
			end
		end
		if (cmd.emit) begin
			stat_q <= cmd.emit_st;
			cnt_q  <= 8'(total_nxt);
		end
	end

	assign done           = done_q;
	assign status         = stat_q;
	assign result_value   = rval_q;
	assign found_position = fpos_q;
	assign item_count     = cnt_q;

endmodule

### dv/list_checker.sv
`timescale 1ns / 1ps
// Scoreboard for positional_list_engine: keeps its own image of the linked list,
// predicts the status word of every accepted command and compares it on done.
// Depends on ple_pkg for the command and status codes.
module list_checker #(
	parameter int CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [2:0] command,
	input  logic [7:0] position,
	input  logic [7:0] item_value,
	input  logic       done,
	input  logic [2:0] status,
	input  logic [7:0] result_value,
	input  logic [7:0] found_position,
	input  logic [7:0] item_count,
	output int         fail_count,
	output int         words_owed,
	output logic [7:0] list_len
);

	import ple_pkg::*;

	typedef struct {
		logic [2:0] op;
		st_t        status;
		logic [7:0] value;
		logic [7:0] found;
		logic [7:0] count;
	} status_word_t;

	logic [7:0]   byte_mem [CAPACITY];
	int           link_mem [CAPACITY];
	int           head_node;
	int           free_node;
	int           total;
	int           fails;
	status_word_t owed_q [$];

	function automatic void clear_image();
		for (int k = 0; k < CAPACITY; k++) begin
			byte_mem[k] = 8'h00;
			link_mem[k] = (k + 1) % CAPACITY;
		end
		head_node = 0;
		free_node = 0;
		total = 0;
	endfunction

	function automatic int node_at(input int pos);
		int p;
		p = head_node;
		for (int k = 1; k < pos; k++)
			p = link_mem[p];
		return p;
	endfunction

	function automatic status_word_t apply_word(input logic [2:0] op, input logic [7:0] pos,
			input logic [7:0] val);
		status_word_t w;
		int n;
		int p;
		int q;
		int at;
		w.op = op;
		w.status = ST_OK;
		w.value = 8'h00;
		w.found = 8'h00;
		at = int'(pos);
		case (op)
			CMD_INSERT: begin
				if (at < 1 || at > total + 1) begin
					w.status = ST_BAD_POS;
				end else if (total >= CAPACITY) begin
					w.status = ST_FULL;
				end else begin
					n = free_node;
					free_node = link_mem[n];
					byte_mem[n] = val;
					if (at == 1) begin
						link_mem[n] = head_node;
						head_node = n;
					end else begin
						p = node_at(at - 1);
						link_mem[n] = link_mem[p];
						link_mem[p] = n;
					end
					total++;
				end
			end
			CMD_DELETE: begin
				if (total == 0) begin
					w.status = ST_EMPTY;
				end else if (at < 1 || at > total) begin
					w.status = ST_BAD_POS;
				end else begin
					if (at == 1) begin
						q = head_node;
						head_node = link_mem[q];
					end else begin
						p = node_at(at - 1);
						q = link_mem[p];
						link_mem[p] = link_mem[q];
					end
					w.value = byte_mem[q];
					link_mem[q] = free_node;
					free_node = q;
					total--;
				end
			end
			CMD_READ: begin
				if (at < 1 || at > total)
					w.status = ST_BAD_POS;
				else
					w.value = byte_mem[node_at(at)];
			end
			CMD_LOCATE: begin
				w.status = ST_NOT_FOUND;
				p = head_node;
				for (int k = 1; k <= total && w.status == ST_NOT_FOUND; k++) begin
					if (byte_mem[p] == val) begin
						w.found = 8'(k);
						w.status = ST_OK;
					end
					p = link_mem[p];
				end
			end
			CMD_CLEAR: begin
				clear_image();
			end
			default: begin
			end
		endcase
		w.count = 8'(total);
		return w;
	endfunction

	function automatic void flag(input string what);
		fails++;
		if (fails <= 10)
			$display("%t list_checker: %s", $realtime, what);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		status_word_t want;
		if (!arst_n) begin
			clear_image();
			owed_q.delete();
			fails = 0;
			fail_count <= 0;
			words_owed <= 0;
			list_len <= 8'h00;
		end else begin
			if (done) begin
				if (owed_q.size() == 0) begin
					flag($sformatf("unexpected word: status %0d value %0d found %0d count %0d",
						status, result_value, found_position, item_count));
				end else begin
					want = owed_q.pop_front();
					if (status !== want.status || result_value !== want.value ||
							found_position !== want.found || item_count !== want.count)
						flag($sformatf({"cmd %0d: expected status %0d value %0d found %0d ",
							"count %0d, got status %0d value %0d found %0d count %0d"},
							want.op, want.status, want.value, want.found, want.count,
							status, result_value, found_position, item_count));
				end
			end
			if (start && !busy)
				owed_q.push_back(apply_word(command, position, item_value));
			fail_count <= fails;
			words_owed <= owed_q.size();
			list_len <= 8'(total);
		end
	end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Top of the positional_list_engine bench: clock, reset, directed and random
// command stimulus, and the verdict. Uses ple_pkg, list_checker, the engine.
module testbench;
	import ple_pkg::*;

	localparam int         CAPACITY     = 64;
	localparam int         RANDOM_WORDS = 700;
	localparam int         CYCLE_LIMIT  = 600000;
	localparam int         DRAIN_CYCLES = 150;
	localparam logic [2:0] CMD_NOP_A    = 3'd6;
	localparam logic [2:0] CMD_NOP_B    = 3'd7;

	typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} load_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [2:0] command = CMD_COUNT;
	logic [7:0] position = 8'h00;
	logic [7:0] item_value = 8'h00;
	logic       busy;
	logic       done;
	logic [2:0] status;
	logic [7:0] result_value;
	logic [7:0] found_position;
	logic [7:0] item_count;
	int         fail_count;
	int         words_owed;
	logic [7:0] list_len;
	int         cycle_count = 0;

	always #5 clk = ~clk;

	positional_list_engine #(.CAPACITY(CAPACITY)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.position(position),
		.item_value(item_value),
		.done(done),
		.status(status),
		.result_value(result_value),
		.found_position(found_position),
		.item_count(item_count)
	);

	list_checker #(.CAPACITY(CAPACITY)) chk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.position(position),
		.item_value(item_value),
		.done(done),
		.status(status),
		.result_value(result_value),
		.found_position(found_position),
		.item_count(item_count),
		.fail_count(fail_count),
		.words_owed(words_owed),
		.list_len(list_len)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[positional_list_engine] ERROR");
			$finish;
		end
	end

	task automatic issue(input logic [2:0] op, input logic [7:0] pos, input logic [7:0] val);
		start <= 1'b1;
		command <= op;
		position <= pos;
		item_value <= val;
		do @(posedge clk); while (busy);
	endtask

	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (words_owed != 0);
	endtask

	function automatic logic [7:0] pick_value();
		int r;
		r = $urandom_range(0, 3);
		if (r < 2)
			return 8'($urandom_range(0, 7));
		else if (r == 2)
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_spot(input int hi);
		if (hi < 1 || $urandom_range(0, 15) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(1, hi));
	endfunction

	initial begin
		load_mode_t mode;
		logic [2:0] op;
		logic [7:0] pos;
		int         counted;
		int         burst_left;
		int         phase_left;
		int         len;
		int         r;
		bit         drained_once;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		issue(CMD_COUNT, 8'd0, 8'h00);
		issue(CMD_READ, 8'd1, 8'h00);
		issue(CMD_DELETE, 8'd1, 8'h00);
		issue(CMD_LOCATE, 8'd0, 8'h00);
		issue(CMD_INSERT, 8'd0, 8'h11);
		issue(CMD_INSERT, 8'd2, 8'h11);
		issue(CMD_INSERT, 8'd1, 8'h00);
		issue(CMD_INSERT, 8'd2, 8'hFF);
		issue(CMD_INSERT, 8'd1, 8'hAA);
		hold_off(3);
		issue(CMD_INSERT, 8'd3, 8'h55);
		issue(CMD_READ, 8'd1, 8'h00);
		issue(CMD_READ, 8'd4, 8'h00);
		issue(CMD_READ, 8'd5, 8'h00);
		issue(CMD_READ, 8'd255, 8'h00);
		issue(CMD_LOCATE, 8'd0, 8'h55);
		issue(CMD_LOCATE, 8'd0, 8'hFF);
		issue(CMD_LOCATE, 8'd0, 8'h12);
		issue(CMD_DELETE, 8'd0, 8'h00);
		issue(CMD_DELETE, 8'd5, 8'h00);
		issue(CMD_DELETE, 8'd4, 8'h00);
		issue(CMD_DELETE, 8'd2, 8'h00);
		issue(CMD_NOP_A, 8'd1, 8'h00);
		issue(CMD_NOP_B, 8'd255, 8'hFF);
		issue(CMD_INSERT, 8'd2, 8'h7E);
		issue(CMD_CLEAR, 8'd0, 8'h00);
		issue(CMD_COUNT, 8'd0, 8'h00);

		counted = 0;
		drained_once = 1'b0;
		mode = MODE_FILL;
		phase_left = 100;
		burst_left = $urandom_range(1, 30);
		while (counted < RANDOM_WORDS) begin
			if (phase_left <= 0) begin
				mode = load_mode_t'($urandom_range(0, 2));
				phase_left = $urandom_range(20, 90);
				if (!drained_once || $urandom_range(0, 3) == 0) begin
					settle();
					drained_once = 1'b1;
				end
			end
			len = int'(list_len);
			r = $urandom_range(0, 99);
			case (mode)
				MODE_FILL: begin
					if (r < 80)      op = CMD_INSERT;
					else if (r < 85) op = CMD_DELETE;
					else if (r < 90) op = CMD_READ;
					else if (r < 95) op = CMD_LOCATE;
					else if (r < 98) op = CMD_COUNT;
					else             op = $urandom_range(0, 1) ? CMD_NOP_A : CMD_NOP_B;
				end
				MODE_DRAIN: begin
					if (r < 60)      op = CMD_DELETE;
					else if (r < 70) op = CMD_INSERT;
					else if (r < 80) op = CMD_READ;
					else if (r < 90) op = CMD_LOCATE;
					else if (r < 96) op = CMD_COUNT;
					else             op = $urandom_range(0, 1) ? CMD_NOP_A : CMD_NOP_B;
				end
				default: begin
					if (r < 30)      op = CMD_INSERT;
					else if (r < 50) op = CMD_DELETE;
					else if (r < 70) op = CMD_READ;
					else if (r < 85) op = CMD_LOCATE;
					else if (r < 92) op = CMD_COUNT;
					else if (r < 98) op = $urandom_range(0, 1) ? CMD_NOP_A : CMD_NOP_B;
					else             op = CMD_CLEAR;
				end
			endcase
			pos = (op == CMD_INSERT) ? pick_spot(len + 1) : pick_spot(len);
			issue(op, pos, pick_value());
			if (op != CMD_NOP_A && op != CMD_NOP_B)
				counted++;
			phase_left--;
			burst_left--;
			if (burst_left <= 0) begin
				hold_off($urandom_range(1, 12));
				burst_left = $urandom_range(1, 40);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && words_owed == 0)
			$display("[positional_list_engine] OK");
		else
			$display("[positional_list_engine] ERROR");
		$finish;
	end

endmodule
